### design/chmc_pkg.sv
// Package for the monotone chain convex hull block: point and item types,
// chain cell operations, controller states and the point ordering function.
// Depends on nothing.
`timescale 1ns / 1ps

package chmc_pkg;

  localparam int COORD_BITS = 16;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pt_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic                         last_vertex;
    logic                         overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_SHL,
    OP_SHR
  } cell_op_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FWD_TEST,
    ST_FWD_CMP,
    ST_REV_SKIP,
    ST_REV_TEST,
    ST_REV_CMP,
    ST_FIN,
    ST_COPY,
    ST_EMIT
  } state_t;

  // Order by x, then by y.
  function automatic logic pt_less(pt_t a, pt_t b);
    pt_less = (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

### design/chmc_cell.sv
// One cell of a point chain: holds a point and can keep it, take a sorted
// insert, or shift from either neighbor. Depends on chmc_pkg.
`timescale 1ns / 1ps

module chmc_cell (
  input  logic              clk,
  input  chmc_pkg::cell_op_t op,
  input  chmc_pkg::pt_t     din,
  input  chmc_pkg::pt_t     left,
  input  chmc_pkg::pt_t     right,
  input  logic              left_less,
  input  logic              valid,
  output chmc_pkg::pt_t     q,
  output logic              less,
  output logic              eq
);

  // Compare the held point against the broadcast point.
  assign less = valid && chmc_pkg::pt_less(q, din);
  assign eq   = valid && (q == din);

  // A cell that is not below the new point takes it or its left neighbor.
  always_ff @(posedge clk) begin
    case (op)
      chmc_pkg::OP_HOLD: q <= q;
      chmc_pkg::OP_INS: begin
        if (!less) begin
          q <= left_less ? din : left;
        end
      end
      chmc_pkg::OP_SHL: q <= right;
      chmc_pkg::OP_SHR: q <= left;
      default: q <= q;
    endcase
  end

endmodule

### design/chmc_chain.sv
// A row of chmc_cell instances with neighbor links, a duplicate detector and
// access to the two head cells. Depends on chmc_pkg and chmc_cell.
`timescale 1ns / 1ps

module chmc_chain #(
  parameter int DEPTH = 32,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  chmc_pkg::cell_op_t op,
  input  chmc_pkg::pt_t      din,
  input  logic [CW-1:0]      count,
  output chmc_pkg::pt_t      q0,
  output chmc_pkg::pt_t      q1,
  output logic               dup
);

  chmc_pkg::pt_t    cq [DEPTH];
  logic [DEPTH-1:0] cl;
  logic [DEPTH-1:0] ce;

  // Cells are linked so cell zero sees the new point as its left neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    chmc_cell u_cell (
      .clk       (clk),
      .op        (op),
      .din       (din),
      .left      ((i == 0) ? din : cq[(i == 0) ? 0 : i - 1]),
      .right     ((i == DEPTH - 1) ? cq[i] : cq[(i == DEPTH - 1) ? i : i + 1]),
      .left_less ((i == 0) ? 1'b1 : cl[(i == 0) ? 0 : i - 1]),
      .valid     (CW'(i) < count),
      .q         (cq[i]),
      .less      (cl[i]),
      .eq        (ce[i])
    );
  end

  assign q0  = cq[0];
  assign q1  = cq[1];
  assign dup = |ce;

endmodule

### design/convex_hull_monotone_chain.sv
// Convex hull by monotone chain over a sorted chain of point cells.
// Load: one point item per cycle (sorted insert); busy stays low.
// Hull: a push goes straight in when there is nothing to test; otherwise the
// cross products are registered first and then compared, and a pop returns to
// the test; each point is pushed about twice, with the turnaround states REV_SKIP
// and FIN between; the stack is then reversed, then one vertex a cycle. The receiver cannot stall.
// Synchronous reset empties the set and returns to loading.
`timescale 1ns / 1ps

module convex_hull_monotone_chain #(
  parameter int MAX_POINTS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  chmc_pkg::in_item_t  point,
  output logic                vertex_valid,
  output chmc_pkg::out_item_t vertex
);

  localparam int MW = $clog2(MAX_POINTS + 1);
  localparam int HW = $clog2(MAX_POINTS + 2);
  localparam int CB = chmc_pkg::COORD_BITS;

  chmc_pkg::state_t state, state_next;
  logic [MW-1:0] scount, scount_next;
  logic [MW-1:0] rem, rem_next;
  logic [HW-1:0] hcount, hcount_next;
  logic [HW-1:0] rcount, rcount_next;
  logic [HW-1:0] kmark, kmark_next;
  logic          dropped, dropped_next;

  chmc_pkg::cell_op_t s_op, h_op, r_op;
  chmc_pkg::pt_t      s_din, h_din, r_din;
  chmc_pkg::pt_t      s_q0, s_q1, h_q0, h_q1, r_q0, r_q1;
  logic               s_dup, h_dup, r_dup;
  chmc_pkg::pt_t      newp, cand;

  logic signed [CB:0]     ux, uy, vx, vy;
  logic signed [2*CB+1:0] prod1, prod2;
  logic                   not_left;

  assign newp.x = point.point_x;
  assign newp.y = point.point_y;

  // Sorted point store, hull stack and reversing chain.
  chmc_chain #(.DEPTH(MAX_POINTS)) u_store (
    .clk(clk), .op(s_op), .din(s_din), .count(scount),
    .q0(s_q0), .q1(s_q1), .dup(s_dup)
  );
  chmc_chain #(.DEPTH(MAX_POINTS + 1)) u_stack (
    .clk(clk), .op(h_op), .din(h_din), .count(hcount),
    .q0(h_q0), .q1(h_q1), .dup(h_dup)
  );
  chmc_chain #(.DEPTH(MAX_POINTS)) u_rev (
    .clk(clk), .op(r_op), .din(r_din), .count(MW'(0)),
    .q0(r_q0), .q1(r_q1), .dup(r_dup)
  );

  // Candidate point comes from the store going forward, the reverser going back.
  assign cand = ((state == chmc_pkg::ST_FWD_TEST) || (state == chmc_pkg::ST_FWD_CMP))
              ? s_q0 : r_q0;

  // Cross product terms against the two top stack entries.
  assign ux = {h_q0.x[CB-1], h_q0.x} - {h_q1.x[CB-1], h_q1.x};
  assign uy = {h_q0.y[CB-1], h_q0.y} - {h_q1.y[CB-1], h_q1.y};
  assign vx = {cand.x[CB-1], cand.x} - {h_q1.x[CB-1], h_q1.x};
  assign vy = {cand.y[CB-1], cand.y} - {h_q1.y[CB-1], h_q1.y};

  always_ff @(posedge clk) begin
    prod1 <= ux * vy;
    prod2 <= uy * vx;
  end

  assign not_left = (prod1 <= prod2);

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= chmc_pkg::ST_LOAD;
      scount  <= '0;
      rem     <= '0;
      hcount  <= '0;
      rcount  <= '0;
      kmark   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      scount  <= scount_next;
      rem     <= rem_next;
      hcount  <= hcount_next;
      rcount  <= rcount_next;
      kmark   <= kmark_next;
      dropped <= dropped_next;
    end
  end

  // Next state, chain operations and outputs.
  always_comb begin
    state_next   = state;
    scount_next  = scount;
    rem_next     = rem;
    hcount_next  = hcount;
    rcount_next  = rcount;
    kmark_next   = kmark;
    dropped_next = dropped;
    s_op  = chmc_pkg::OP_HOLD;
    h_op  = chmc_pkg::OP_HOLD;
    r_op  = chmc_pkg::OP_HOLD;
    s_din = newp;
    h_din = cand;
    r_din = s_q0;
    busy  = 1'b1;
    vertex_valid       = 1'b0;
    vertex.hull_x      = r_q0.x;
    vertex.hull_y      = r_q0.y;
    vertex.last_vertex = (rcount == HW'(1));
    vertex.overflow    = dropped;
    case (state)
      chmc_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          if (!s_dup) begin
            if (scount == MW'(MAX_POINTS)) begin
              dropped_next = 1'b1;
            end else begin
              s_op        = chmc_pkg::OP_INS;
              scount_next = scount + MW'(1);
            end
          end
          if (point.last_point) begin
            rem_next   = scount_next;
            state_next = chmc_pkg::ST_FWD_TEST;
          end
        end
      end
      chmc_pkg::ST_FWD_TEST, chmc_pkg::ST_FWD_CMP,
      chmc_pkg::ST_REV_TEST, chmc_pkg::ST_REV_CMP: begin
        if ((state == chmc_pkg::ST_FWD_TEST) && (hcount > HW'(1))) begin
          state_next = chmc_pkg::ST_FWD_CMP;
        end else if ((state == chmc_pkg::ST_REV_TEST) && (hcount > kmark)) begin
          state_next = chmc_pkg::ST_REV_CMP;
        end else if (((state == chmc_pkg::ST_FWD_CMP) || (state == chmc_pkg::ST_REV_CMP))
                     && not_left) begin
          // Pop the top vertex and test again.
          h_op        = chmc_pkg::OP_SHL;
          hcount_next = hcount - HW'(1);
          state_next  = (state == chmc_pkg::ST_FWD_CMP) ? chmc_pkg::ST_FWD_TEST
                                                         : chmc_pkg::ST_REV_TEST;
        end else begin
          // Push the candidate and consume it.
          h_op        = chmc_pkg::OP_SHR;
          hcount_next = hcount + HW'(1);
          rem_next    = rem - MW'(1);
          if ((state == chmc_pkg::ST_FWD_TEST) || (state == chmc_pkg::ST_FWD_CMP)) begin
            s_op = chmc_pkg::OP_SHL;
            r_op = chmc_pkg::OP_SHR;
            if (rem == MW'(1)) begin
              kmark_next = hcount + HW'(1);
              state_next = chmc_pkg::ST_REV_SKIP;
            end else begin
              state_next = chmc_pkg::ST_FWD_TEST;
            end
          end else begin
            r_op       = chmc_pkg::OP_SHL;
            state_next = (rem == MW'(1)) ? chmc_pkg::ST_FIN : chmc_pkg::ST_REV_TEST;
          end
        end
      end
      chmc_pkg::ST_REV_SKIP: begin
        // The greatest point already closes the lower chain.
        r_op     = chmc_pkg::OP_SHL;
        rem_next = scount - MW'(1);
        state_next = (scount == MW'(1)) ? chmc_pkg::ST_FIN : chmc_pkg::ST_REV_TEST;
      end
      chmc_pkg::ST_FIN: begin
        // Drop the repeated least point at the top.
        if (scount > MW'(1)) begin
          h_op        = chmc_pkg::OP_SHL;
          hcount_next = hcount - HW'(1);
        end
        state_next = chmc_pkg::ST_COPY;
      end
      chmc_pkg::ST_COPY: begin
        // Reverse the stack so the bottom vertex comes out first.
        h_op        = chmc_pkg::OP_SHL;
        r_op        = chmc_pkg::OP_SHR;
        r_din       = h_q0;
        hcount_next = hcount - HW'(1);
        rcount_next = rcount + HW'(1);
        if (hcount == HW'(1)) begin
          state_next = chmc_pkg::ST_EMIT;
        end
      end
      chmc_pkg::ST_EMIT: begin
        vertex_valid = 1'b1;
        r_op         = chmc_pkg::OP_SHL;
        rcount_next  = rcount - HW'(1);
        if (rcount == HW'(1)) begin
          scount_next  = '0;
          dropped_next = 1'b0;
          state_next   = chmc_pkg::ST_LOAD;
        end
      end
      default: state_next = chmc_pkg::ST_LOAD;
    endcase
  end

  // Checks on the controller.
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    vertex_valid |-> busy) else $error("vertex while not busy");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (vertex_valid && vertex.last_vertex) |=> !busy) else $error("no idle after hull");
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    (state == chmc_pkg::ST_LOAD) |-> ((hcount == '0) && (rcount == '0)))
    else $error("stack not empty while loading");
  a_stack_cap: assert property (@(posedge clk) disable iff (rst)
    hcount <= HW'(MAX_POINTS + 1)) else $error("stack overrun");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the monotone chain convex hull block.
// Drives point items, predicts each hull in SystemVerilog and checks every vertex.
// Depends on chmc_pkg and convex_hull_monotone_chain.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_PTS = 32;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  chmc_pkg::in_item_t point = '0;
  logic vertex_valid;
  chmc_pkg::out_item_t vertex;

  convex_hull_monotone_chain #(.MAX_POINTS(MAX_PTS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point(point), .vertex_valid(vertex_valid), .vertex(vertex)
  );

  always #5 clk = ~clk;

  // Pending items, expected vertices and the predictor's copy of the point set.
  chmc_pkg::in_item_t pending_points[$];
  chmc_pkg::out_item_t expected_vertices[$];
  chmc_pkg::pt_t sorted_set[$];
  logic set_dropped = 1'b0;
  int error_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit stimulus_done = 1'b0;
  bit drain_hold = 1'b0;

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    error_count++;
  endtask

  // Append one item to the pending queue.
  task automatic queue_point(input chmc_pkg::in_item_t it);
    pending_points = {pending_points, it};
  endtask

  // Cross product of (b - a) and (c - a) is zero or negative.
  function automatic bit turns_right(chmc_pkg::pt_t a, chmc_pkg::pt_t b, chmc_pkg::pt_t c);
    longint ux, uy, vx, vy;
    ux = longint'(b.x) - longint'(a.x);
    uy = longint'(b.y) - longint'(a.y);
    vx = longint'(c.x) - longint'(a.x);
    vy = longint'(c.y) - longint'(a.y);
    return ux * vy <= uy * vx;
  endfunction

  // Sorted insertion of one point; on a closing item, queue the hull vertices.
  task automatic predict_hull(input chmc_pkg::in_item_t it);
    chmc_pkg::pt_t p, chain[$];
    int pos, lower_len, n;
    bit dup;
    p.x = it.point_x;
    p.y = it.point_y;
    pos = 0;
    while (pos < sorted_set.size() && chmc_pkg::pt_less(sorted_set[pos], p)) pos++;
    dup = pos < sorted_set.size() && sorted_set[pos] == p;
    if (!dup) begin
      if (sorted_set.size() >= MAX_PTS) set_dropped = 1'b1;
      else sorted_set.insert(pos, p);
    end
    if (!it.last_point) return;
    n = sorted_set.size();
    for (int i = 0; i < n; i++) begin
      while (chain.size() > 1 &&
             turns_right(chain[chain.size()-2], chain[chain.size()-1], sorted_set[i]))
        void'(chain.pop_back());
      chain = {chain, sorted_set[i]};
    end
    lower_len = chain.size();
    for (int i = n - 2; i >= 0; i--) begin
      while (chain.size() > lower_len &&
             turns_right(chain[chain.size()-2], chain[chain.size()-1], sorted_set[i]))
        void'(chain.pop_back());
      chain = {chain, sorted_set[i]};
    end
    if (n > 1) void'(chain.pop_back());
    foreach (chain[i]) begin
      chmc_pkg::out_item_t v;
      v.hull_x = chain[i].x;
      v.hull_y = chain[i].y;
      v.last_vertex = (i == chain.size() - 1);
      v.overflow = set_dropped;
      expected_vertices = {expected_vertices, v};
    end
    sorted_set.delete();
    set_dropped = 1'b0;
  endtask

  // Driver: holds start until the item is taken, then waits a random gap.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_hull(point);
        void'(pending_points.pop_front());
        gap_left = $urandom_range(0, 5);
        if (pending_points.size() != 0 && pending_points[0].last_point === 1'bx) begin
          drain_hold = 1'b1;
        end
      end
      if (drain_hold && expected_vertices.size() == 0 && !(start && !busy))
        drain_hold = 1'b0;
      if (pending_points.size() != 0 && pending_points[0].last_point === 1'bx) begin
        // A marker item only requests a drain pause.
        if (!drain_hold && !(start && !busy)) begin
          void'(pending_points.pop_front());
          drain_hold = 1'b1;
        end
      end
      if (start && !busy && gap_left > 0) begin
        start <= 1'b0;
      end else if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (!drain_hold && pending_points.size() != 0 &&
                   pending_points[0].last_point !== 1'bx) begin
        start <= 1'b1;
        point <= pending_points[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed vertex is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (vertex_valid) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch("vertex with none expected");
        end else begin
          chmc_pkg::out_item_t e;
          e = expected_vertices.pop_front();
          if (vertex.hull_x !== e.hull_x)
            report_mismatch($sformatf("hull_x %0d, expected %0d", vertex.hull_x, e.hull_x));
          if (vertex.hull_y !== e.hull_y)
            report_mismatch($sformatf("hull_y %0d, expected %0d", vertex.hull_y, e.hull_y));
          if (vertex.last_vertex !== e.last_vertex)
            report_mismatch($sformatf("last_vertex %b, expected %b",
                                      vertex.last_vertex, e.last_vertex));
          if (vertex.overflow !== e.overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      vertex.overflow, e.overflow));
        end
      end
      // Watchdog on cycles without any accepted item or vertex.
      if ((start && !busy) || vertex_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("convex_hull_monotone_chain verification failed");
        $finish;
      end
    end
  end

  function automatic chmc_pkg::in_item_t make_point(int x, int y, bit last);
    chmc_pkg::in_item_t it;
    it.point_x = 16'(x);
    it.point_y = 16'(y);
    it.last_point = last;
    return it;
  endfunction

  // Queue one set of points; the last item closes it.
  task automatic add_random_set(input int count, input int span);
    int cx, cy, x, y;
    cx = $urandom_range(0, 65535) - 32768;
    cy = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          x = $urandom_range(0, 65535) - 32768;
          y = $urandom_range(0, 65535) - 32768;
        end
        1: begin  // collinear along a diagonal
          x = cx + $urandom_range(0, span);
          y = cy + (x - cx);
        end
        2: begin  // corner coordinates
          x = $urandom_range(0, 1) ? 32767 : -32768;
          y = $urandom_range(0, 1) ? 32767 : -32768;
        end
        default: begin
          x = cx + $urandom_range(0, 2 * span) - span;
          y = cy + $urandom_range(0, 2 * span) - span;
        end
      endcase
      queue_point(make_point(x, y, i == count - 1));
      if ($urandom_range(0, 7) == 0 && i != count - 1)
        queue_point(make_point(x, y, 1'b0));  // duplicate point
    end
  endtask

  function automatic chmc_pkg::in_item_t drain_marker();
    chmc_pkg::in_item_t m;
    m = '0;
    m.last_point = 1'bx;
    return m;
  endfunction

  initial begin
    int drained;
    // Directed: single point, two points, collinear, extremes, duplicates.
    queue_point(make_point(-32768, 32767, 1'b1));
    queue_point(make_point(5, 5, 1'b0));
    queue_point(make_point(5, 5, 1'b1));
    queue_point(make_point(32767, -32768, 1'b0));
    queue_point(make_point(-32768, 32767, 1'b1));
    for (int i = 0; i < 4; i++) queue_point(make_point(i, 2 * i, i == 3));
    queue_point(make_point(-32768, -32768, 1'b0));
    queue_point(make_point(32767, -32768, 1'b0));
    queue_point(make_point(32767, 32767, 1'b0));
    queue_point(make_point(0, 0, 1'b0));
    queue_point(make_point(-32768, 32767, 1'b1));
    queue_point(drain_marker());
    // Random sets, including some beyond capacity.
    while (pending_points.size() < 320) begin
      if ($urandom_range(0, 9) == 0) add_random_set($urandom_range(33, 40), 30000);
      else add_random_set($urandom_range(1, 12), $urandom_range(0, 1) ? 4 : 20000);
      if ($urandom_range(0, 5) == 0) queue_point(drain_marker());
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_points.size() == 0 && !start);
    wait (expected_vertices.size() == 0);
    drained = 0;
    while (drained < 300) begin
      @(posedge clk);
      drained++;
    end
    if (error_count == 0 && expected_vertices.size() == 0)
      $display("convex_hull_monotone_chain verification clean");
    else
      $display("convex_hull_monotone_chain verification failed");
    $finish;
  end

endmodule

### files.f
design/chmc_pkg.sv
design/chmc_cell.sv
design/chmc_chain.sv
design/convex_hull_monotone_chain.sv
sim/tb_top.sv
